// ----- rtl/uud_pkg.sv -----
`default_nettype none

package uud_pkg;

   localparam int CHAR_W     = 8;
   localparam int SEXTET_W   = 6;
   localparam int GROUP_W    = 24;
   localparam int BUF_W      = 18;
   localparam int COUNT_W    = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

   // one queue entry: all results caused by one accepted character
   typedef struct packed {
      logic [GROUP_W-1:0] group;   // bytes taken from the top, zeros after
      logic [COUNT_W-1:0] count;   // number of results, never zero
      logic               is_end;  // end-of-body marker
   } uud_cmd_type;

   localparam int CMD_W = $bits(uud_cmd_type);

endpackage

`default_nettype wire

// ----- rtl/uud_front.sv -----
`default_nettype none

module uud_front
   import uud_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [CHAR_W-1:0] in_char,
   output logic                   push,
   output uud_cmd_type            cmd
);

   logic                at_start_ff, at_start_in;
   logic                skipping_ff, skipping_in;
   logic [COUNT_W-1:0]  bytes_left_ff, bytes_left_in;
   logic [1:0]          sextet_cnt_ff, sextet_cnt_in;
   logic [BUF_W-1:0]    sextet_buf_ff, sextet_buf_in;

   logic                is_nl;
   logic [SEXTET_W-1:0] sextet;
   logic [COUNT_W-1:0]  take;
   logic [GROUP_W-1:0]  pad_group;

   assign is_nl  = (in_char == NEWLINE_CHAR);
   // (c - 32) & 63: subtracting 32 mod 64 just flips bit 5
   assign sextet = {~in_char[5], in_char[4:0]};
   assign take   = (bytes_left_ff >= COUNT_W'(3)) ? COUNT_W'(3) : bytes_left_ff;

   // partial group at a newline, missing sextets taken as zero
   always_comb begin
      unique case (sextet_cnt_ff)
         2'd1:    pad_group = {sextet_buf_ff[SEXTET_W-1:0], 18'd0};
         2'd2:    pad_group = {sextet_buf_ff[2*SEXTET_W-1:0], 12'd0};
         2'd3:    pad_group = {sextet_buf_ff, 6'd0};
         default: pad_group = '0;
      endcase
   end

   always_comb begin
      at_start_in   = at_start_ff;
      skipping_in   = skipping_ff;
      bytes_left_in = bytes_left_ff;
      sextet_cnt_in = sextet_cnt_ff;
      sextet_buf_in = sextet_buf_ff;
      push          = 1'b0;
      cmd.group     = '0;
      cmd.count     = COUNT_W'(1);
      cmd.is_end    = 1'b0;
      if (accept) begin
         priority if (skipping_ff) begin
            if (is_nl) begin
               skipping_in = 1'b0;
               at_start_in = 1'b1;
            end
         end else if (at_start_ff) begin
            sextet_cnt_in = '0;
            sextet_buf_in = '0;
            bytes_left_in = '0;
            if (is_nl) begin
               push       = 1'b1;
               cmd.is_end = 1'b1;
            end else begin
               at_start_in = 1'b0;
               if (sextet == '0) begin
                  skipping_in = 1'b1;
                  push        = 1'b1;
                  cmd.is_end  = 1'b1;
               end else begin
                  bytes_left_in = sextet;
               end
            end
         end else if (is_nl) begin
            push          = (bytes_left_ff != '0);
            cmd.group     = pad_group;
            cmd.count     = bytes_left_ff;
            bytes_left_in = '0;
            sextet_cnt_in = '0;
            sextet_buf_in = '0;
            at_start_in   = 1'b1;
         end else if (bytes_left_ff != '0) begin
            if (sextet_cnt_ff != 2'd3) begin
               sextet_buf_in = {sextet_buf_ff[BUF_W-SEXTET_W-1:0], sextet};
               sextet_cnt_in = sextet_cnt_ff + 2'd1;
            end else begin
               push          = 1'b1;
               cmd.group     = {sextet_buf_ff, sextet};
               cmd.count     = take;
               bytes_left_in = bytes_left_ff - take;
               sextet_cnt_in = '0;
               sextet_buf_in = '0;
            end
         end else begin
            // past the count: ignored until the newline
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff   <= 1'b1;
         skipping_ff   <= 1'b0;
         bytes_left_ff <= '0;
         sextet_cnt_ff <= '0;
      end else begin
         at_start_ff   <= at_start_in;
         skipping_ff   <= skipping_in;
         bytes_left_ff <= bytes_left_in;
         sextet_cnt_ff <= sextet_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sextet_buf_ff <= sextet_buf_in;
   end

endmodule

`default_nettype wire

// ----- rtl/uud_queue.sv -----
`default_nettype none

module uud_queue
   import uud_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  wire uud_cmd_type wr_cmd,
   input  wire logic  pop,
   output uud_cmd_type rd_cmd,
   output logic       full,
   output logic       empty
);

   uud_cmd_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign rd_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/uud_back.sv -----
`default_nettype none

module uud_back
   import uud_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire uud_cmd_type q_cmd,
   input  wire logic  q_empty,
   output logic       pop,
   output logic       out_valid,
   input  wire logic  out_ready,
   output logic [CHAR_W-1:0] out_byte,
   output logic       out_end,
   output logic       out_last
);

   logic               busy_ff, busy_in;
   logic [GROUP_W-1:0] group_ff, group_in;
   logic [COUNT_W-1:0] remain_ff, remain_in;
   logic               is_end_ff, is_end_in;

   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  byte_ff, byte_in;
   logic               end_ff, end_in;
   logic               last_ff, last_in;

   logic step;
   logic final_step;

   assign step       = busy_ff && (!valid_ff || out_ready);
   assign final_step = step && (remain_ff == COUNT_W'(1));
   assign pop        = !q_empty && (!busy_ff || final_step);

   always_comb begin
      busy_in   = busy_ff;
      group_in  = group_ff;
      remain_in = remain_ff;
      is_end_in = is_end_ff;
      if (pop) begin
         busy_in   = 1'b1;
         group_in  = q_cmd.group;
         remain_in = q_cmd.count;
         is_end_in = q_cmd.is_end;
      end else if (step) begin
         // shifting in zeros supplies the padding bytes of a short line
         group_in  = {group_ff[GROUP_W-CHAR_W-1:0], {CHAR_W{1'b0}}};
         remain_in = remain_ff - COUNT_W'(1);
         busy_in   = !final_step;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      if (step) begin
         valid_in = 1'b1;
         byte_in  = group_ff[GROUP_W-1 -: CHAR_W];
         end_in   = is_end_ff;
         last_in  = (remain_ff == COUNT_W'(1));
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      group_ff  <= group_in;
      remain_ff <= remain_in;
      is_end_ff <= is_end_in;
      byte_ff   <= byte_in;
      end_ff    <= end_in;
      last_ff   <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_end   = end_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

// ----- rtl/uudecode_line_decoder.sv -----
// uudecode line decoder.
// req_*: one character of the encoded body per item; 10 ends a line. The first
//   character of a line is the byte count, a zero count or an empty line gives
//   an end-of-body marker and the rest of that line is skipped.
// rsp_*: one decoded byte per item; tuser marks the end marker (data zero),
//   tlast marks the final item caused by one input character.
// A front stage parses characters and writes one entry per result-producing
// character into a two-entry queue; a back stage turns an entry into 1 to 63
// output items, one per cycle unless rsp_tready stalls, via a registered output.
// Throughput: one character per cycle while the queue has room; output runs
// at one item per cycle while rsp_tready is high. A newline on a short line
// produces up to 63 items from one character, and the front stalls only once
// the queue is full. A result item passes through a queue entry, the back
// stage's group register and the output register. When rsp_tready is low the
// output register and the back stage hold, the queue fills, and req_tready drops.
// Reset (synchronous) empties the queue, drops rsp_tvalid and makes the next
// character a line's count character.
`default_nettype none

module uudecode_line_decoder
   import uud_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [CHAR_W-1:0] req_tdata,   // [7:0] in_char
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [CHAR_W-1:0]      rsp_tdata,   // [7:0] out_byte
   output logic                   rsp_tuser,   // [0] is_end
   output logic                   rsp_tlast    // last item for one input character
);

   logic        accept;
   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_empty;
   uud_cmd_type wr_cmd;
   uud_cmd_type rd_cmd;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   uud_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_char (req_tdata),
      .push    (q_push),
      .cmd     (wr_cmd)
   );

   uud_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_cmd (wr_cmd),
      .pop    (q_pop),
      .rd_cmd (rd_cmd),
      .full   (q_full),
      .empty  (q_empty)
   );

   uud_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_cmd     (rd_cmd),
      .q_empty   (q_empty),
      .pop       (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_end   (rsp_tuser),
      .out_last  (rsp_tlast)
   );

   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0 && rsp_tlast)
      else $error("end marker carries data or is not last");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue read while empty");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full && accept)
      else $error("queue written without room or without an item");

endmodule

`default_nettype wire
